// ===== rtl/sha1sh_pkg.sv =====
`default_nettype none

package sha1sh_pkg;

	localparam int WORD_W   = 32;
	localparam int WIN_WORDS = 16;
	localparam int CHAIN_WORDS = 5;
	localparam int ROUNDS   = 80;
	localparam int FILL_W   = 7;
	localparam int COUNT_W  = 61;
	localparam int IDX_W    = 3;
	localparam int VB_W     = 3;
	localparam int RND_W    = 7;

	localparam logic [FILL_W-1:0]  BLOCK_BYTES  = 7'd64;
	localparam logic [FILL_W-1:0]  LAST_BYTE    = 7'd63;
	localparam logic [FILL_W-1:0]  LEN_START    = 7'd56;
	localparam logic [RND_W-1:0]   LAST_ROUND   = 7'd79;
	localparam logic [IDX_W-1:0]   LAST_IDX     = 3'd4;
	localparam logic [VB_W-1:0]    MAX_BYTES    = 3'd4;
	localparam logic [7:0]         PAD_BYTE     = 8'h80;

	localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
	localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
	localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

	localparam logic [WORD_W-1:0] IV [CHAIN_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic REQ_ABSORB = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} sha1sh_state_t;

	typedef enum logic [1:0] {
		RET_ABSORB,
		RET_LEN,
		RET_EMIT
	} sha1sh_ret_t;

	function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] x);
		return {x[WORD_W-2:0], x[WORD_W-1]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] x);
		return {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] x);
		return {x[1:0], x[WORD_W-1:2]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_stream_hasher.sv =====
`default_nettype none

// Streaming SHA-1 hasher. Each absorb transaction carries up to four message
// bytes, first byte in data_word[31:24]; valid_bytes above four counts as four and
// zero is taken and dropped. A finish transaction pads the message, appends the
// 64-bit bit length and then delivers five digest transactions, word 0 (most
// significant) first, with last_word set on word 4; the hasher is then back at
// the initial chaining values for the next message. The block takes one transaction
// at a time. An absorb is accepted and its bytes are then packed into the block
// buffer one per cycle; a byte that completes a 64-byte block starts the 80 rounds
// on the single shared round adder, followed by the chaining update. A finish is
// accepted, writes the pad byte and the length and runs a compression, with a
// further compression before the length when the pad byte lands at offset 56 or
// later, then delivers five digest transactions at one per cycle while out_stall
// is low. Streaming full words thus spreads the compression of each block over
// the sixteen absorb transactions that filled it.
module sha1_stream_hasher
	import sha1sh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [WORD_W-1:0] data_word,
	input  wire logic [VB_W-1:0]   valid_bytes,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      digest_word,
	output logic [IDX_W-1:0]       word_index,
	output logic                   last_word
);

	sha1sh_state_t state_q, state_d;
	sha1sh_ret_t   ret_q, ret_d;

	logic [WORD_W-1:0]  chain_q [CHAIN_WORDS];
	// block buffer doubles as the message schedule window during rounds
	logic [WORD_W-1:0]  win_q [WIN_WORDS];
	logic [WORD_W-1:0]  a_q, b_q, c_q, d_q, e_q;
	logic [RND_W-1:0]   rnd_q;
	logic [FILL_W-1:0]  fill_q;
	logic [COUNT_W-1:0] msg_q;
	logic [WORD_W-1:0]  data_q;
	logic [VB_W-1:0]    cnt_q;
	logic [IDX_W-1:0]   idx_q;

	logic               in_acc, out_acc;
	logic [VB_W-1:0]    cnt_in;
	logic               wr_byte;
	logic [7:0]         byte_val;
	logic               start_rnd;
	logic [WORD_W-1:0]  w_new, f_val, k_val, t_val;
	logic [63:0]        bit_len;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign cnt_in  = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
	assign bit_len = {msg_q, 3'b000};
	assign start_rnd = (state_d == ST_ROUND) && (state_q != ST_ROUND);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_FINISH) begin
						state_d = ST_PAD;
					end else if (cnt_in != '0) begin
						state_d = ST_ABSORB;
					end
				end
			end
			ST_ABSORB: begin
				if (fill_q == LAST_BYTE) begin
					state_d = ST_ROUND;
					ret_d   = RET_ABSORB;
				end else if (cnt_q == VB_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				// pad byte at offset 56 or beyond leaves no room for the length
				if (fill_q >= LEN_START) begin
					state_d = ST_ROUND;
					ret_d   = RET_LEN;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				state_d = ST_ROUND;
				ret_d   = RET_EMIT;
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				unique case (ret_q)
					RET_ABSORB: state_d = (cnt_q != '0) ? ST_ABSORB : ST_IDLE;
					RET_LEN:    state_d = ST_LEN;
					RET_EMIT:   state_d = ST_EMIT;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_EMIT: begin
				if (!out_stall && idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		wr_byte   = 1'b0;
		byte_val  = data_q[WORD_W-1 -: 8];
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_ABSORB: wr_byte = 1'b1;
			ST_PAD: begin
				wr_byte  = 1'b1;
				byte_val = PAD_BYTE;
			end
			ST_EMIT:   out_valid = 1'b1;
			default:   ;
		endcase
	end

	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_IDX);

	// shared round datapath
	always_comb begin
		if (rnd_q < RND_W'(16)) begin
			w_new = win_q[0];
		end else begin
			w_new = rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
		end
		if (rnd_q < RND_W'(20)) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (rnd_q < RND_W'(40)) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (rnd_q < RND_W'(60)) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
		t_val = rotl5(a_q) + f_val + e_q + w_new + k_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_ABSORB;
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= IV[i];
			end
			for (int i = 0; i < WIN_WORDS; i++) begin
				win_q[i] <= '0;
			end
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
			d_q    <= '0;
			e_q    <= '0;
			rnd_q  <= '0;
			fill_q <= '0;
			msg_q  <= '0;
			data_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;

			// take an absorb transaction
			if (in_acc && req_type == REQ_ABSORB && cnt_in != '0) begin
				data_q <= data_word;
				cnt_q  <= cnt_in;
				msg_q  <= msg_q + COUNT_W'(cnt_in);
			end

			// pack one byte per cycle, message byte or pad byte
			if (wr_byte) begin
				case (fill_q[1:0])
					2'd0: win_q[fill_q[5:2]][31:24] <= byte_val;
					2'd1: win_q[fill_q[5:2]][23:16] <= byte_val;
					2'd2: win_q[fill_q[5:2]][15:8]  <= byte_val;
					default: win_q[fill_q[5:2]][7:0] <= byte_val;
				endcase
				fill_q <= fill_q + FILL_W'(1);
				if (state_q == ST_ABSORB) begin
					data_q <= {data_q[WORD_W-9:0], 8'h00};
					cnt_q  <= cnt_q - VB_W'(1);
				end
			end

			// length into the last two buffer words
			if (state_q == ST_LEN) begin
				win_q[14] <= bit_len[63:32];
				win_q[15] <= bit_len[31:0];
			end

			if (start_rnd) begin
				a_q   <= chain_q[0];
				b_q   <= chain_q[1];
				c_q   <= chain_q[2];
				d_q   <= chain_q[3];
				e_q   <= chain_q[4];
				rnd_q <= '0;
			end

			if (state_q == ST_ROUND) begin
				a_q   <= t_val;
				b_q   <= a_q;
				c_q   <= rotl30(b_q);
				d_q   <= c_q;
				e_q   <= d_q;
				rnd_q <= rnd_q + RND_W'(1);
				for (int i = 0; i < WIN_WORDS - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WIN_WORDS-1] <= w_new;
			end

			// chaining update, buffer emptied for the next block
			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				for (int i = 0; i < WIN_WORDS; i++) begin
					win_q[i] <= '0;
				end
				fill_q <= '0;
			end

			// digest transactions, then back to a fresh message
			if (out_acc) begin
				if (idx_q == LAST_IDX) begin
					idx_q <= '0;
					for (int i = 0; i < CHAIN_WORDS; i++) begin
						chain_q[i] <= IV[i];
					end
					fill_q <= '0;
					msg_q  <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	// no input transaction while the digest is being delivered
	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during digest output");

	// between transactions the buffer never holds a full block
	a_idle_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q < BLOCK_BYTES))
		else $error("full block left uncompressed");

	// round counter stays within the compression
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= LAST_ROUND))
		else $error("round counter overran");

	// the last digest word leaves the hasher on a fresh message
	a_fresh_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (fill_q == '0 && msg_q == '0 && idx_q == '0))
		else $error("message state not cleared after digest");

endmodule

`default_nettype wire
